// ===== hw/rtl/wsc_pkg.sv =====
// ----------------------------------------------------------------------------
// wsc_pkg - shared definitions for the waveform shape classifier
// Register indexes, reset values, the wave kind codes and the structs that
// pass between the top level and the window statistics unit.
// ----------------------------------------------------------------------------
package wsc_pkg;

  // Field widths
  localparam int SampleW   = 10;
  localparam int SlopeW    = SampleW + 1;
  localparam int CountW    = 8;
  localparam int WinLenW   = 8;
  localparam int FlatLimW  = 10;
  localparam int StrLimW   = 11;
  localparam int CfgDataW  = 11;
  localparam int CfgIndexW = 3;

  // Register indexes on the configuration port
  localparam logic [CfgIndexW-1:0] REG_WINDOW_LENGTH   = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_FLAT_LIMIT      = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_STRAIGHT_LIMIT  = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_FLAT_NEEDED     = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_STRAIGHT_NEEDED = 3'd4;

  // Register values after reset
  localparam logic [WinLenW-1:0]  RST_WINDOW_LENGTH   = 8'd50;
  localparam logic [FlatLimW-1:0] RST_FLAT_LIMIT      = 10'd5;
  localparam logic [StrLimW-1:0]  RST_STRAIGHT_LIMIT  = 11'd10;
  localparam logic [CountW-1:0]   RST_FLAT_NEEDED     = 8'd30;
  localparam logic [CountW-1:0]   RST_STRAIGHT_NEEDED = 8'd20;

  typedef enum logic [1:0] {
    KIND_SQUARE   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_SINE     = 2'd2
  } wave_kind_t;

  typedef struct packed {
    logic [WinLenW-1:0]  window_length;
    logic [FlatLimW-1:0] flat_limit;
    logic [StrLimW-1:0]  straight_limit;
    logic [CountW-1:0]   flat_needed;
    logic [CountW-1:0]   straight_needed;
  } wsc_cfg_t;

  typedef struct packed {
    logic              last;
    wave_kind_t        kind;
    logic [CountW-1:0] flat_total;
    logic [CountW-1:0] straight_total;
  } wsc_stat_t;

endpackage

// ===== hw/rtl/wsc_stats.sv =====
// ----------------------------------------------------------------------------
// wsc_stats - window statistics for the waveform shape classifier
// Forms first and second differences of the sample stream, keeps the flat and
// straight counts and the position in the window, and classifies the window
// on its last sample.
// ----------------------------------------------------------------------------
module wsc_stats
  import wsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic [SampleW-1:0] sample,
  input  wsc_cfg_t           cfg,
  output wsc_stat_t          stat
);

  logic [SampleW-1:0] prev_sample_r;
  logic [SlopeW-1:0]  prev_slope_r;
  logic [CountW-1:0]  flat_r;
  logic [CountW-1:0]  straight_r;
  logic [WinLenW-1:0] index_r;

  logic [SlopeW-1:0]   slope;
  logic [SlopeW-1:0]   slope_neg;
  logic [FlatLimW-1:0] slope_mag;
  logic [SlopeW:0]     bend;
  logic [SlopeW:0]     bend_neg;
  logic [StrLimW-1:0]  bend_mag;
  logic                flat_hit;
  logic                straight_hit;
  logic [CountW-1:0]   flat_nxt;
  logic [CountW-1:0]   straight_nxt;
  logic [WinLenW:0]    pos_plus1;
  logic                last;
  wave_kind_t          kind;

  // First difference: previous minus current
  assign slope     = {1'b0, prev_sample_r} - {1'b0, sample};
  assign slope_neg = -slope;
  assign slope_mag = slope[SlopeW-1] ? slope_neg[FlatLimW-1:0] : slope[FlatLimW-1:0];

  // Second difference: previous slope minus current slope
  assign bend     = {prev_slope_r[SlopeW-1], prev_slope_r} - {slope[SlopeW-1], slope};
  assign bend_neg = -bend;
  assign bend_mag = bend[SlopeW] ? bend_neg[StrLimW-1:0] : bend[StrLimW-1:0];

  // Count only real differences
  assign flat_hit     = (index_r != '0) && (slope_mag < cfg.flat_limit);
  assign straight_hit = (index_r > WinLenW'(1)) && (bend_mag < cfg.straight_limit);

  // Saturating count update
  assign flat_nxt     = (flat_hit && (flat_r != '1)) ? flat_r + 1'b1 : flat_r;
  assign straight_nxt = (straight_hit && (straight_r != '1)) ? straight_r + 1'b1 : straight_r;

  // Window ends once the position reaches the programmed length
  assign pos_plus1 = {1'b0, index_r} + 1'b1;
  assign last      = pos_plus1 >= {1'b0, cfg.window_length};

  // Classify from the counts including this sample
  always_comb begin
    priority if (flat_nxt >= cfg.flat_needed) begin
      kind = KIND_SQUARE;
    end else if (straight_nxt >= cfg.straight_needed) begin
      kind = KIND_TRIANGLE;
    end else begin
      kind = KIND_SINE;
    end
  end

  assign stat.last           = last;
  assign stat.kind           = kind;
  assign stat.flat_total     = flat_nxt;
  assign stat.straight_total = straight_nxt;

  // Advance the window state on each sample taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sample_r <= '0;
      prev_slope_r  <= '0;
      flat_r        <= '0;
      straight_r    <= '0;
      index_r       <= '0;
    end else if (advance) begin
      prev_sample_r <= sample;
      prev_slope_r  <= slope;
      if (last) begin
        flat_r     <= '0;
        straight_r <= '0;
        index_r    <= '0;
      end else begin
        flat_r     <= flat_nxt;
        straight_r <= straight_nxt;
        index_r    <= pos_plus1[WinLenW-1:0];
      end
    end
  end

endmodule

// ===== hw/rtl/waveform_shape_classifier_top.sv =====
// The classifier takes one 10-bit sample per clock cycle while its input is not
// stalled and returns one request per window on its final sample, carrying the
// wave kind and the flat and straight counts. A sample passes an input register
// and then the difference, compare and count logic into the result register.
// Samples that do not end a window keep flowing while a result waits; only a
// window-ending sample waits in the input register until the result register
// is free.
// ----------------------------------------------------------------------------
// waveform_shape_classifier_top - waveform shape classifier
// Input register, configuration registers, result register and handshakes
// around the window statistics unit.
// ----------------------------------------------------------------------------
module waveform_shape_classifier_top
  import wsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SampleW-1:0]   in_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_wave_kind,
  output logic [CountW-1:0]    out_flat_total,
  output logic [CountW-1:0]    out_straight_total,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata
);

  wsc_cfg_t           cfg_r;
  logic               s1_valid_r;
  logic [SampleW-1:0] s1_sample_r;
  logic               out_valid_r;
  wave_kind_t         out_kind_r;
  logic [CountW-1:0]  out_flat_r;
  logic [CountW-1:0]  out_straight_r;

  wsc_stat_t stat;
  logic      out_free;
  logic      advance;
  logic      in_take;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_length   <= RST_WINDOW_LENGTH;
      cfg_r.flat_limit      <= RST_FLAT_LIMIT;
      cfg_r.straight_limit  <= RST_STRAIGHT_LIMIT;
      cfg_r.flat_needed     <= RST_FLAT_NEEDED;
      cfg_r.straight_needed <= RST_STRAIGHT_NEEDED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH:   cfg_r.window_length   <= cfg_wdata[WinLenW-1:0];
        REG_FLAT_LIMIT:      cfg_r.flat_limit      <= cfg_wdata[FlatLimW-1:0];
        REG_STRAIGHT_LIMIT:  cfg_r.straight_limit  <= cfg_wdata[StrLimW-1:0];
        REG_FLAT_NEEDED:     cfg_r.flat_needed     <= cfg_wdata[CountW-1:0];
        REG_STRAIGHT_NEEDED: cfg_r.straight_needed <= cfg_wdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the held sample unless it ends a window and the result slot is busy
  assign out_free = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && (!stat.last || out_free);
  assign in_ready = !s1_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  wsc_stats u_stats (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .sample  (s1_sample_r),
    .cfg     (cfg_r),
    .stat    (stat)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r <= in_sample;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && stat.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stat.last) begin
      out_kind_r     <= stat.kind;
      out_flat_r     <= stat.flat_total;
      out_straight_r <= stat.straight_total;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_wave_kind      = out_kind_r;
  assign out_flat_total     = out_flat_r;
  assign out_straight_total = out_straight_r;

endmodule

// ===== hw/rtl/wsc_checker.sv =====
// ----------------------------------------------------------------------------
// wsc_checker - port-level checks for the waveform shape classifier
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module wsc_checker
  import wsc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_wave_kind,
  input logic [CountW-1:0]  out_flat_total,
  input logic [CountW-1:0]  out_straight_total
);

  // Drop any pending result on reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result request pending after reset");

  // Hold a stalled result request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_wave_kind)
      && $stable(out_flat_total) && $stable(out_straight_total))
    else $error("stalled result request changed");

  // Only the three defined kinds leave the block
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_wave_kind != 2'd3)
    else $error("undefined wave kind");

  // Input side is open in the cycle after reset
  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_ready)
    else $error("input not ready after reset");

  // Stall the input only behind a waiting result
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with no waiting result");

endmodule

bind waveform_shape_classifier_top wsc_checker u_wsc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_wave_kind      (out_wave_kind),
  .out_flat_total     (out_flat_total),
  .out_straight_total (out_straight_total)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - waveform shape classifier
// Drives sample requests with bursty timing and a stalling result side.
// Every result is checked against the table's expected values for checked
// directed rows, else against a cycle-free classifier model kept here. A directed
// table comes first, then randomised square, ramp, rail and noise waveforms under changing window settings.
// ----------------------------------------------------------------------------
module testbench
  import wsc_pkg::*;
();

  localparam int CYCLE_LIMIT    = 300000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_SAMPLES = 650;
  localparam int NUM_DIRECTED   = 44;

  // Indexes that map to no register
  localparam logic [CfgIndexW-1:0] REG_UNUSED_FIRST = 3'd5;
  localparam logic [CfgIndexW-1:0] REG_UNUSED_LAST  = 3'd7;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_op_t;
  typedef enum int {SHAPE_SQUARE, SHAPE_RAMP, SHAPE_RAIL, SHAPE_NOISE} shape_t;
  typedef enum int {READY_ALWAYS, READY_COIN, READY_ONE_IN_FOUR, READY_MOSTLY} ready_mode_t;

  typedef struct {
    wave_kind_t        kind;
    logic [CountW-1:0] flat;
    logic [CountW-1:0] straight;
  } window_reading_t;

  typedef struct {
    row_op_t              op;
    logic [CfgIndexW-1:0] index;
    logic [CfgDataW-1:0]  value;
    bit                   checked;
    wave_kind_t           kind;
    logic [CountW-1:0]    flat;
    logic [CountW-1:0]    straight;
  } step_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [SampleW-1:0]   in_sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_wave_kind;
  logic [CountW-1:0]    out_flat_total;
  logic [CountW-1:0]    out_straight_total;
  logic                 cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_wdata = '0;

  // Classifier model: settings and window state
  logic [WinLenW-1:0]        win_len;
  logic [FlatLimW-1:0]       flat_lim;
  logic [StrLimW-1:0]        straight_lim;
  logic [CountW-1:0]         flat_need;
  logic [CountW-1:0]         straight_need;
  logic [SampleW-1:0]        last_sample;
  logic signed [SlopeW-1:0]  last_slope;
  logic [CountW-1:0]         flat_seen;
  logic [CountW-1:0]         straight_seen;
  logic [WinLenW-1:0]        position;

  window_reading_t expected_windows[$];
  int              mismatch_count = 0;
  int              cycle_count = 0;
  int              burst_left = 0;
  int              ready_left = 0;
  ready_mode_t     ready_mode = READY_ALWAYS;

  // Waveform generator state
  shape_t gen_shape;
  int     gen_level;
  int     gen_step;
  int     gen_noise;
  int     gen_hold;

  // Extremes, every kind, zero limits and thresholds, short windows,
  // unmapped indexes and a window cut short mid-way
  step_row_t directed_steps [NUM_DIRECTED] = '{
    '{ROW_WRITE,  REG_WINDOW_LENGTH,   11'd3,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_WRITE,  REG_FLAT_NEEDED,     11'd2,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_WRITE,  REG_STRAIGHT_NEEDED, 11'd1,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd0,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd0,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd0,    1'b1, KIND_SQUARE,   8'd2, 8'd1},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd1023, 1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd0,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd1023, 1'b1, KIND_SINE,     8'd0, 8'd0},
    '{ROW_WRITE,  REG_STRAIGHT_LIMIT,  11'd2047, 1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd1023, 1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd0,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd1023, 1'b1, KIND_TRIANGLE, 8'd0, 8'd1},
    '{ROW_WRITE,  REG_FLAT_LIMIT,      11'd0,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_WRITE,  REG_STRAIGHT_LIMIT,  11'd0,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd5,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd5,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd5,    1'b1, KIND_SINE,     8'd0, 8'd0},
    '{ROW_WRITE,  REG_FLAT_NEEDED,     11'd0,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd7,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd300,  1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd9,    1'b1, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_WRITE,  REG_FLAT_NEEDED,     11'd2,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_WRITE,  REG_STRAIGHT_NEEDED, 11'd0,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_WRITE,  REG_WINDOW_LENGTH,   11'd1,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd100,  1'b1, KIND_TRIANGLE, 8'd0, 8'd0},
    '{ROW_WRITE,  REG_WINDOW_LENGTH,   11'd0,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd200,  1'b1, KIND_TRIANGLE, 8'd0, 8'd0},
    '{ROW_WRITE,  REG_WINDOW_LENGTH,   11'd2,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_WRITE,  REG_FLAT_LIMIT,      11'd1023, 1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd10,   1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd11,   1'b1, KIND_TRIANGLE, 8'd1, 8'd0},
    '{ROW_WRITE,  REG_WINDOW_LENGTH,   11'd6,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_WRITE,  REG_FLAT_LIMIT,      11'd5,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_WRITE,  REG_STRAIGHT_LIMIT,  11'd10,   1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_WRITE,  REG_STRAIGHT_NEEDED, 11'd20,   1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_WRITE,  REG_UNUSED_FIRST,    11'd2047, 1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_WRITE,  REG_UNUSED_LAST,     11'd0,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd40,   1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd41,   1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd43,   1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd44,   1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_WRITE,  REG_WINDOW_LENGTH,   11'd3,    1'b0, KIND_SQUARE,   8'd0, 8'd0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH,   11'd45,   1'b0, KIND_SQUARE,   8'd0, 8'd0}
  };

  waveform_shape_classifier_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_wave_kind      (out_wave_kind),
    .out_flat_total     (out_flat_total),
    .out_straight_total (out_straight_total),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the model by one sample; flag a finished window
  task automatic classify_sample(input logic [SampleW-1:0] s, output bit done,
                                 output window_reading_t reading);
    int slope;
    int bend;
    int slope_mag;
    int bend_mag;
    slope     = int'(last_sample) - int'(s);
    bend      = int'(last_slope) - slope;
    slope_mag = slope < 0 ? -slope : slope;
    bend_mag  = bend < 0 ? -bend : bend;
    done      = 1'b0;
    if (position >= 1) begin
      if (slope_mag < int'(flat_lim) && flat_seen != '1) flat_seen++;
      if (position >= 2 && bend_mag < int'(straight_lim) && straight_seen != '1)
        straight_seen++;
    end
    last_slope  = slope[SlopeW-1:0];
    last_sample = s;
    if (int'(position) + 1 >= int'(win_len)) begin
      done = 1'b1;
      if (flat_seen >= flat_need) reading.kind = KIND_SQUARE;
      else if (straight_seen >= straight_need) reading.kind = KIND_TRIANGLE;
      else reading.kind = KIND_SINE;
      reading.flat     = flat_seen;
      reading.straight = straight_seen;
      flat_seen        = '0;
      straight_seen    = '0;
      position         = '0;
    end else begin
      position++;
    end
  endtask

  // Send one sample request, opening a new burst after a random gap
  task automatic push_sample(input logic [SampleW-1:0] s, input bit typed,
                             input window_reading_t typed_reading);
    int              gap;
    bit              done;
    window_reading_t reading;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    classify_sample(s, done, reading);
    if (done) expected_windows.push_back(typed ? typed_reading : reading);
  endtask

  // Hold off until every result is in and the pipeline has drained
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIndexW-1:0] idx,
                                input logic [CfgDataW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    unique case (idx)
      REG_WINDOW_LENGTH:   win_len       = value[WinLenW-1:0];
      REG_FLAT_LIMIT:      flat_lim      = value[FlatLimW-1:0];
      REG_STRAIGHT_LIMIT:  straight_lim  = value[StrLimW-1:0];
      REG_FLAT_NEEDED:     flat_need     = value[CountW-1:0];
      REG_STRAIGHT_NEEDED: straight_need = value[CountW-1:0];
      default: ;
    endcase
  endtask

  // Next sample of the current waveform, with optional noise
  function automatic logic [SampleW-1:0] next_waveform_sample();
    int v;
    unique case (gen_shape)
      SHAPE_SQUARE: begin
        if (gen_hold == 0) begin
          gen_level = 1023 - gen_level;
          gen_hold  = $urandom_range(2, 12);
        end
        gen_hold--;
        v = gen_level;
      end
      SHAPE_RAMP: begin
        if (gen_level + gen_step > 1023 || gen_level + gen_step < 0) gen_step = -gen_step;
        gen_level += gen_step;
        v = gen_level;
      end
      SHAPE_RAIL: v = ($urandom_range(0, 1) == 1) ? 1023 : 0;
      default:    v = $urandom_range(0, 1023);
    endcase
    if (gen_noise > 0) v += int'($urandom_range(0, 2 * gen_noise)) - gen_noise;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[SampleW-1:0];
  endfunction

  // Result side stalls on a pattern that is picked again at random when its run ends
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_left = $urandom_range(16, 96);
    end
    ready_left--;
    unique case (ready_mode)
      READY_ALWAYS:      out_ready <= 1'b1;
      READY_COIN:        out_ready <= ($urandom_range(0, 1) == 1);
      READY_ONE_IN_FOUR: out_ready <= (ready_left % 4 == 0);
      default:           out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Compare each accepted result with the oldest pending window
  always @(posedge clk) begin
    window_reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_windows.size() == 0) begin
        $error("unexpected result: wave_kind %0d flat_total %0d straight_total %0d",
               out_wave_kind, out_flat_total, out_straight_total);
        mismatch_count++;
      end else begin
        want = expected_windows.pop_front();
        if (out_wave_kind !== want.kind) begin
          $error("wave_kind: expected %0d, got %0d", want.kind, out_wave_kind);
          mismatch_count++;
        end
        if (out_flat_total !== want.flat) begin
          $error("flat_total: expected %0d, got %0d", want.flat, out_flat_total);
          mismatch_count++;
        end
        if (out_straight_total !== want.straight) begin
          $error("straight_total: expected %0d, got %0d", want.straight, out_straight_total);
          mismatch_count++;
        end
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("waveform_shape_classifier_top verification failed");
      $finish;
    end
  end

  initial begin
    int                   random_sent;
    int                   n;
    int                   sel;
    logic [WinLenW-1:0]   wl;
    logic [FlatLimW-1:0]  fl;
    logic [StrLimW-1:0]   sl;
    logic [CountW-1:0]    fn;
    logic [CountW-1:0]    sn;
    window_reading_t      typed_reading;

    win_len       = RST_WINDOW_LENGTH;
    flat_lim      = RST_FLAT_LIMIT;
    straight_lim  = RST_STRAIGHT_LIMIT;
    flat_need     = RST_FLAT_NEEDED;
    straight_need = RST_STRAIGHT_NEEDED;
    last_sample   = '0;
    last_slope    = '0;
    flat_seen     = '0;
    straight_seen = '0;
    position      = '0;
    random_sent   = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_steps[i]) begin
      if (directed_steps[i].op == ROW_WRITE) begin
        settle_block();
        write_register(directed_steps[i].index, directed_steps[i].value);
      end else begin
        typed_reading.kind     = directed_steps[i].kind;
        typed_reading.flat     = directed_steps[i].flat;
        typed_reading.straight = directed_steps[i].straight;
        push_sample(directed_steps[i].value[SampleW-1:0], directed_steps[i].checked,
                    typed_reading);
      end
    end

    // Random phases: new settings, then one waveform, often ending mid-window
    while (random_sent < RANDOM_SAMPLES) begin
      settle_block();
      sel = $urandom_range(0, 11);
      if (sel == 0) wl = 8'd255;
      else if (sel == 1) wl = 8'($urandom_range(0, 2));
      else if (sel == 2) wl = 8'd50;
      else wl = 8'($urandom_range(3, 24));
      sel = $urandom_range(0, 5);
      fl = (sel == 0) ? 10'd0 : (sel == 1) ? 10'd1023 : 10'($urandom_range(1, 24));
      sel = $urandom_range(0, 5);
      sl = (sel == 0) ? 11'd0 : (sel == 1) ? 11'd2047 : 11'($urandom_range(1, 48));
      sel = $urandom_range(0, 5);
      fn = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom_range(0, wl));
      sel = $urandom_range(0, 5);
      sn = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom_range(0, wl));
      // upper data bits beyond each register are junk and must be dropped
      write_register(REG_WINDOW_LENGTH,   {3'($urandom), wl});
      write_register(REG_FLAT_LIMIT,      {1'($urandom), fl});
      write_register(REG_STRAIGHT_LIMIT,  sl);
      write_register(REG_FLAT_NEEDED,     {3'($urandom), fn});
      write_register(REG_STRAIGHT_NEEDED, {3'($urandom), sn});
      if ($urandom_range(0, 7) == 0)
        write_register(CfgIndexW'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                       11'($urandom));

      sel = $urandom_range(0, 19);
      if (sel < 7) gen_shape = SHAPE_SQUARE;
      else if (sel < 14) gen_shape = SHAPE_RAMP;
      else if (sel < 16) gen_shape = SHAPE_RAIL;
      else gen_shape = SHAPE_NOISE;
      gen_level = $urandom_range(0, 1023);
      gen_step  = int'($urandom_range(1, 40));
      if ($urandom_range(0, 1) == 1) gen_step = -gen_step;
      gen_noise = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
      gen_hold  = $urandom_range(1, 12);

      if (wl == 8'd255) n = 255 + $urandom_range(0, 10);
      else if (wl == 8'd50) n = 50 + $urandom_range(0, 60);
      else n = (wl < 2 ? 2 : int'(wl)) * $urandom_range(2, 6) + $urandom_range(0, wl);
      repeat (n) push_sample(next_waveform_sample(), 1'b0, typed_reading);
      random_sent += n;
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("waveform_shape_classifier_top verification clean");
    end else begin
      $display("waveform_shape_classifier_top verification failed");
    end
    $finish;
  end

endmodule
